[rtl/nwt_pkg.sv]
// Shared types and constants for the hit-count window trigger.
`timescale 1ns / 1ps
`default_nettype none
package nwt_pkg;

	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 16;
	localparam int WIN_W      = 27;
	localparam int QDEPTH     = 4;

	localparam logic [CFG_ADDR_W-1:0] REG_THRESHOLD   = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_WINDOW_BINS = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_SKIP_BINS   = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_CHAN_ENABLE = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] REG_TRIG_CHAN_A = 3'd4;
	localparam logic [CFG_ADDR_W-1:0] REG_TRIG_TYPE_A = 3'd5;
	localparam logic [CFG_ADDR_W-1:0] REG_TRIG_CHAN_B = 3'd6;
	localparam logic [CFG_ADDR_W-1:0] REG_TRIG_TYPE_B = 3'd7;

	localparam logic [15:0] THRESHOLD_RST   = 16'd20;
	localparam logic [10:0] WINDOW_BINS_RST = 11'd200;
	localparam logic [11:0] SKIP_BINS_RST   = 12'd2000;

	localparam logic [1:0] REQ_OPEN  = 2'd0;
	localparam logic [1:0] REQ_HIT   = 2'd1;
	localparam logic [1:0] REQ_CLOSE = 2'd2;

	localparam logic [1:0] KIND_CHAN  = 2'd0;
	localparam logic [1:0] KIND_NHITS = 2'd1;
	localparam logic [1:0] KIND_DONE  = 2'd2;

	typedef struct packed {
		logic [15:0] threshold;
		logic [10:0] window_bins;
		logic [11:0] skip_bins;
		logic [1:0]  chan_enable;
		logic [15:0] trig_chan_a;
		logic [3:0]  trig_type_a;
		logic [15:0] trig_chan_b;
		logic [3:0]  trig_type_b;
	} cfg_t;

	typedef enum logic [1:0] {
		OP_CHAN,
		OP_HIT,
		OP_CLEAR,
		OP_SCAN
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [3:0]  ttype;
		logic [63:0] tstamp;
	} qent_t;

	localparam int QENT_W = $bits(qent_t);

endpackage
`default_nettype wire

[rtl/nhits_window_trigger_core.sv]
// Top level of the hit-count window trigger: configuration registers and block wiring.
// With the back end idle, a channel trigger goes through the command queue and is strobed
// from the result register; a close item runs a window scan, one bin per cycle. Throughput:
// one hit per cycle while the back end is idle; the histogram read-modify-write forwards
// back-to-back bins. An open item, and reset itself, start a clearing sweep of every bin;
// items queue meanwhile and busy rises when the four-entry command queue is full.
// Results are strobed for one cycle each; the receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none
module nhits_window_trigger_core #(
	parameter int NUM_BINS     = 4096,
	parameter int BIN_SHIFT    = 9,
	parameter int MAX_TRIGGERS = 63,
	parameter int CHAN_ENTRIES = 2
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	output logic                                 busy,
	input  wire logic [1:0]                      req_type,
	input  wire logic [15:0]                     channel,
	input  wire logic [63:0]                     hit_time,
	input  wire logic [63:0]                     slice_time,
	input  wire logic                            cfg_we,
	input  wire logic [nwt_pkg::CFG_ADDR_W-1:0]  cfg_addr,
	input  wire logic [nwt_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	output logic                                 strobe,
	output logic [1:0]                           kind,
	output logic [3:0]                           trig_type,
	output logic [63:0]                          trig_time,
	output logic                                 overflow,
	output logic                                 last
);
	import nwt_pkg::*;

	localparam int IW = $clog2(NUM_BINS);
	localparam int QW = QENT_W + IW;

	cfg_t          cfg_q;
	logic          accept;
	logic          f_push;
	qent_t         f_entry;
	logic [IW-1:0] f_bin;
	logic [QW-1:0] q_din;
	logic [QW-1:0] q_dout;
	logic          q_pop;
	logic          q_empty;
	logic          q_full;
	qent_t         q_entry;
	logic [IW-1:0] q_bin;

	assign busy    = q_full;
	assign accept  = start && !busy;
	assign q_din   = {f_entry, f_bin};
	assign q_entry = q_dout[QW-1:IW];
	assign q_bin   = q_dout[IW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold   <= THRESHOLD_RST;
			cfg_q.window_bins <= WINDOW_BINS_RST;
			cfg_q.skip_bins   <= SKIP_BINS_RST;
			cfg_q.chan_enable <= 2'd0;
			cfg_q.trig_chan_a <= 16'd0;
			cfg_q.trig_type_a <= 4'd0;
			cfg_q.trig_chan_b <= 16'd0;
			cfg_q.trig_type_b <= 4'd0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_THRESHOLD:   cfg_q.threshold   <= cfg_wdata;
				REG_WINDOW_BINS: cfg_q.window_bins <= cfg_wdata[10:0];
				REG_SKIP_BINS:   cfg_q.skip_bins   <= cfg_wdata[11:0];
				REG_CHAN_ENABLE: cfg_q.chan_enable <= cfg_wdata[1:0];
				REG_TRIG_CHAN_A: cfg_q.trig_chan_a <= cfg_wdata;
				REG_TRIG_TYPE_A: cfg_q.trig_type_a <= cfg_wdata[3:0];
				REG_TRIG_CHAN_B: cfg_q.trig_chan_b <= cfg_wdata;
				REG_TRIG_TYPE_B: cfg_q.trig_type_b <= cfg_wdata[3:0];
				default:         cfg_q             <= cfg_q;
			endcase
		end
	end

	nwt_front #(
		.NUM_BINS     (NUM_BINS),
		.BIN_SHIFT    (BIN_SHIFT),
		.CHAN_ENTRIES (CHAN_ENTRIES),
		.IW           (IW)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.accept     (accept),
		.req_type   (req_type),
		.channel    (channel),
		.hit_time   (hit_time),
		.slice_time (slice_time),
		.push       (f_push),
		.entry      (f_entry),
		.bin        (f_bin)
	);

	nwt_queue #(
		.DATA_W (QW),
		.DEPTH  (QDEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (f_push),
		.din    (q_din),
		.pop    (q_pop),
		.dout   (q_dout),
		.empty  (q_empty),
		.full   (q_full)
	);

	nwt_back #(
		.NUM_BINS     (NUM_BINS),
		.BIN_SHIFT    (BIN_SHIFT),
		.MAX_TRIGGERS (MAX_TRIGGERS),
		.IW           (IW)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_empty   (q_empty),
		.q_entry   (q_entry),
		.q_bin     (q_bin),
		.q_pop     (q_pop),
		.strobe    (strobe),
		.kind      (kind),
		.trig_type (trig_type),
		.trig_time (trig_time),
		.overflow  (overflow),
		.last      (last)
	);

`ifndef SYNTHESIS
	// A queued command is never taken from an empty queue.
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("command taken from an empty queue");

	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (kind == KIND_CHAN || kind == KIND_NHITS || kind == KIND_DONE))
		else $error("result with an unknown kind");

	// Overflow and the last flag belong to the done marker alone.
	a_flags_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && (overflow || last)) |-> (kind == KIND_DONE && last))
		else $error("overflow or last flag on a trigger result");

	a_nhits_type_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && kind == KIND_NHITS) |-> (trig_type == 4'd0))
		else $error("nhits trigger with a nonzero type");
`endif

endmodule
`default_nettype wire

[rtl/nwt_front.sv]
// Front end: accepts items, matches trigger channels and computes histogram bins.
`timescale 1ns / 1ps
`default_nettype none
module nwt_front #(
	parameter int NUM_BINS     = 4096,
	parameter int BIN_SHIFT    = 9,
	parameter int CHAN_ENTRIES = 2,
	parameter int IW           = 12
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire nwt_pkg::cfg_t     cfg,
	input  wire logic              accept,
	input  wire logic [1:0]        req_type,
	input  wire logic [15:0]       channel,
	input  wire logic [63:0]       hit_time,
	input  wire logic [63:0]       slice_time,
	output logic                   push,
	output nwt_pkg::qent_t         entry,
	output logic [IW-1:0]          bin
);
	import nwt_pkg::*;

	logic [63:0] slice_start_q;
	logic [63:0] diff;
	logic [63:0] bin_wide;
	logic        in_range;
	logic        match_a;
	logic        match_b;

	assign diff     = hit_time - slice_start_q;
	assign bin_wide = diff >> BIN_SHIFT;
	// A hit before the slice start wraps to a huge bin and falls out here.
	assign in_range = bin_wide < 64'(NUM_BINS);
	assign bin      = bin_wide[IW-1:0];
	assign match_a  = cfg.chan_enable[0] && (channel == cfg.trig_chan_a);
	assign match_b  = (CHAN_ENTRIES > 1) && cfg.chan_enable[1] && (channel == cfg.trig_chan_b);

	always_comb begin
		push         = 1'b0;
		entry.op     = OP_HIT;
		entry.ttype  = 4'd0;
		entry.tstamp = hit_time;
		unique case (req_type)
			REQ_OPEN: begin
				push     = accept;
				entry.op = OP_CLEAR;
			end
			REQ_HIT: begin
				if (match_a) begin
					push        = accept;
					entry.op    = OP_CHAN;
					entry.ttype = cfg.trig_type_a;
				end else if (match_b) begin
					push        = accept;
					entry.op    = OP_CHAN;
					entry.ttype = cfg.trig_type_b;
				end else begin
					push = accept && in_range;
				end
			end
			REQ_CLOSE: begin
				push         = accept;
				entry.op     = OP_SCAN;
				entry.tstamp = slice_start_q;
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slice_start_q <= 64'd0;
		end else if (accept && (req_type == REQ_OPEN)) begin
			slice_start_q <= slice_time;
		end
	end

endmodule
`default_nettype wire

[rtl/nwt_queue.sv]
// Small command queue between the front end and the histogram engine.
`timescale 1ns / 1ps
`default_nettype none
module nwt_queue #(
	parameter int DATA_W = 8,
	parameter int DEPTH  = 4
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire logic [DATA_W-1:0] din,
	input  wire logic              pop,
	output logic [DATA_W-1:0]      dout,
	output logic                   empty,
	output logic                   full
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CNTW-1:0] DEPTH_C = CNTW'(DEPTH);

	logic [DATA_W-1:0] slot_q [DEPTH];
	logic [PW-1:0]     wr_ptr_q;
	logic [PW-1:0]     rd_ptr_q;
	logic [CNTW-1:0]   count_q;
	logic              do_push;
	logic              do_pop;

	assign empty   = (count_q == '0);
	assign full    = (count_q == DEPTH_C);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNTW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNTW'(1);
			end
		end
	end

endmodule
`default_nettype wire

[rtl/nwt_back.sv]
// Back end: bin histogram memory, clearing sweep, window scan and result register.
`timescale 1ns / 1ps
`default_nettype none
module nwt_back #(
	parameter int NUM_BINS     = 4096,
	parameter int BIN_SHIFT    = 9,
	parameter int MAX_TRIGGERS = 63,
	parameter int IW           = 12
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire nwt_pkg::cfg_t  cfg,
	input  wire logic           q_empty,
	input  wire nwt_pkg::qent_t q_entry,
	input  wire logic [IW-1:0]  q_bin,
	output logic                q_pop,
	output logic                strobe,
	output logic [1:0]          kind,
	output logic [3:0]          trig_type,
	output logic [63:0]         trig_time,
	output logic                overflow,
	output logic                last
);
	import nwt_pkg::*;

	localparam int CW = ((IW > 12) ? IW : 12) + 2;
	localparam logic [IW-1:0] LAST_BIN = IW'(NUM_BINS - 1);
	localparam logic [CW-1:0] NB_C = CW'(NUM_BINS);
	localparam logic [6:0] MAX_C = 7'(MAX_TRIGGERS);

	typedef enum logic [1:0] {
		B_CLEAR,
		B_IDLE,
		B_SCAN,
		B_DONE
	} bstate_t;

	bstate_t state_q;

	logic [15:0] mem_q [NUM_BINS];
	logic [15:0] rd_a_q;
	logic [15:0] rd_b_q;
	logic        mem_we;
	logic [IW-1:0] mem_waddr;
	logic [15:0] mem_wdata;
	logic [IW-1:0] rd_addr_a;
	logic [IW-1:0] rd_addr_b;

	logic [IW-1:0] clr_idx_q;

	logic          hit_v_s1;
	logic [IW-1:0] hit_bin_s1;
	logic          fwd_v_q;
	logic [IW-1:0] fwd_addr_q;
	logic [15:0]   fwd_data_q;
	logic [15:0]   hit_old;
	logic [15:0]   hit_new;

	logic          scan_iss_q;
	logic [IW-1:0] j_q;
	logic          sc_v_s1;
	logic [IW-1:0] sc_j_s1;
	logic          sc_sub_s1;
	logic          sc_v_s2;
	logic [IW-1:0] sc_j_s2;
	logic [WIN_W-1:0] win_q;
	logic [CW-1:0] next_q;
	logic [6:0]    cnt_q;
	logic          ovf_q;
	logic [63:0]   start_q;

	logic [CW-1:0] w_c;
	logic [CW-1:0] j_c;
	logic [CW-1:0] j2_c;
	logic [CW-1:0] jw_c;
	logic [CW-1:0] off_c;
	logic          sub_now;
	logic          in_win;
	logic          fire;
	logic          last_pos;
	logic [WIN_W-1:0] win_sub;

	assign q_pop = (state_q == B_IDLE) && !q_empty;

	// Only the hit written in the previous cycle can collide with the current read.
	assign hit_old = (fwd_v_q && (fwd_addr_q == hit_bin_s1)) ? fwd_data_q : rd_a_q;
	assign hit_new = (hit_old == 16'hFFFF) ? hit_old : hit_old + 16'd1;

	assign mem_we    = (state_q == B_CLEAR) || hit_v_s1;
	assign mem_waddr = (state_q == B_CLEAR) ? clr_idx_q : hit_bin_s1;
	assign mem_wdata = (state_q == B_CLEAR) ? 16'd0 : hit_new;

	assign w_c       = CW'(cfg.window_bins);
	assign j_c       = CW'(j_q);
	assign jw_c      = j_c - w_c;
	assign sub_now   = j_c >= w_c;
	assign rd_addr_a = (state_q == B_SCAN) ? j_q : q_bin;
	assign rd_addr_b = jw_c[IW-1:0];

	// The running sum covers bins (j - window, j] once j has reached the window width.
	assign win_sub  = sc_sub_s1 ? WIN_W'(rd_b_q) : '0;
	assign j2_c     = CW'(sc_j_s2);
	assign off_c    = j2_c - w_c;
	assign in_win   = (j2_c >= (w_c + CW'(1))) && ((j2_c + w_c) < NB_C) && (j2_c >= next_q);
	assign fire     = sc_v_s2 && in_win && (win_q >= WIN_W'(cfg.threshold));
	assign last_pos = sc_v_s2 && (sc_j_s2 == LAST_BIN);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_waddr] <= mem_wdata;
		end
		rd_a_q <= mem_q[rd_addr_a];
		rd_b_q <= mem_q[rd_addr_b];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= B_CLEAR;
			clr_idx_q  <= '0;
			hit_v_s1   <= 1'b0;
			hit_bin_s1 <= '0;
			fwd_v_q    <= 1'b0;
			fwd_addr_q <= '0;
			fwd_data_q <= 16'd0;
			scan_iss_q <= 1'b0;
			j_q        <= '0;
			sc_v_s1    <= 1'b0;
			sc_j_s1    <= '0;
			sc_sub_s1  <= 1'b0;
			sc_v_s2    <= 1'b0;
			sc_j_s2    <= '0;
			win_q      <= '0;
			next_q     <= '0;
			cnt_q      <= 7'd0;
			ovf_q      <= 1'b0;
			start_q    <= 64'd0;
			strobe     <= 1'b0;
			kind       <= KIND_DONE;
			trig_type  <= 4'd0;
			trig_time  <= 64'd0;
			overflow   <= 1'b0;
			last       <= 1'b0;
		end else begin
			strobe     <= 1'b0;
			hit_v_s1   <= 1'b0;
			fwd_v_q    <= hit_v_s1;
			fwd_addr_q <= hit_bin_s1;
			fwd_data_q <= hit_new;
			unique case (state_q)
				B_CLEAR: begin
					if (clr_idx_q == LAST_BIN) begin
						clr_idx_q <= '0;
						state_q   <= B_IDLE;
					end else begin
						clr_idx_q <= clr_idx_q + IW'(1);
					end
				end
				B_IDLE: begin
					if (q_pop) begin
						unique case (q_entry.op)
							OP_CHAN: begin
								strobe    <= 1'b1;
								kind      <= KIND_CHAN;
								trig_type <= q_entry.ttype;
								trig_time <= q_entry.tstamp;
								overflow  <= 1'b0;
								last      <= 1'b0;
							end
							OP_HIT: begin
								hit_v_s1   <= 1'b1;
								hit_bin_s1 <= q_bin;
							end
							OP_CLEAR: begin
								state_q <= B_CLEAR;
							end
							OP_SCAN: begin
								start_q    <= q_entry.tstamp;
								j_q        <= '0;
								scan_iss_q <= 1'b1;
								sc_v_s1    <= 1'b0;
								sc_v_s2    <= 1'b0;
								win_q      <= '0;
								next_q     <= '0;
								cnt_q      <= 7'd0;
								ovf_q      <= 1'b0;
								state_q    <= B_SCAN;
							end
							default: begin
								state_q <= B_IDLE;
							end
						endcase
					end
				end
				B_SCAN: begin
					if (scan_iss_q) begin
						j_q <= j_q + IW'(1);
						if (j_q == LAST_BIN) begin
							scan_iss_q <= 1'b0;
						end
					end
					sc_v_s1   <= scan_iss_q;
					sc_j_s1   <= j_q;
					sc_sub_s1 <= sub_now;
					sc_v_s2   <= sc_v_s1;
					sc_j_s2   <= sc_j_s1;
					if (sc_v_s1) begin
						win_q <= win_q + WIN_W'(rd_a_q) - win_sub;
					end
					if (fire) begin
						if (cnt_q >= MAX_C) begin
							ovf_q   <= 1'b1;
							state_q <= B_DONE;
						end else begin
							strobe    <= 1'b1;
							kind      <= KIND_NHITS;
							trig_type <= 4'd0;
							trig_time <= (64'(off_c) << BIN_SHIFT) + start_q;
							overflow  <= 1'b0;
							last      <= 1'b0;
							cnt_q     <= cnt_q + 7'd1;
							next_q    <= j2_c + CW'(cfg.skip_bins) + CW'(1);
							if (last_pos) begin
								state_q <= B_DONE;
							end
						end
					end else if (last_pos) begin
						state_q <= B_DONE;
					end
				end
				B_DONE: begin
					strobe    <= 1'b1;
					kind      <= KIND_DONE;
					trig_type <= 4'd0;
					trig_time <= 64'd0;
					overflow  <= ovf_q;
					last      <= 1'b1;
					scan_iss_q <= 1'b0;
					state_q   <= B_IDLE;
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

[bench/tb_top.sv]
// Self-checking testbench for the hit-count window trigger core.
`timescale 1ns / 1ps
module tb_top;
	import nwt_pkg::*;

	localparam int NUM_BINS     = 4096;
	localparam int BIN_SHIFT    = 9;
	localparam int MAX_TRIGGERS = 63;
	localparam int IDLE_WAIT    = NUM_BINS + 16;
	localparam int STALL_LIMIT  = 40000;
	localparam int RANDOM_ITEMS = 170;
	localparam int BURST_HITS   = 24;
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	typedef struct packed {
		logic [1:0]  kind;
		logic [3:0]  ttype;
		logic [63:0] ttime;
		logic        ovf;
		logic        last;
	} trig_result_t;

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	logic [1:0]            req_type;
	logic [15:0]           channel;
	logic [63:0]           hit_time;
	logic [63:0]           slice_time;
	logic                  cfg_we;
	logic [CFG_ADDR_W-1:0] cfg_addr;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	logic                  strobe;
	logic [1:0]            kind;
	logic [3:0]            trig_type;
	logic [63:0]           trig_time;
	logic                  overflow;
	logic                  last;

	nhits_window_trigger_core #(
		.NUM_BINS(NUM_BINS),
		.BIN_SHIFT(BIN_SHIFT),
		.MAX_TRIGGERS(MAX_TRIGGERS),
		.CHAN_ENTRIES(2)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req_type(req_type),
		.channel(channel),
		.hit_time(hit_time),
		.slice_time(slice_time),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata),
		.strobe(strobe),
		.kind(kind),
		.trig_type(trig_type),
		.trig_time(trig_time),
		.overflow(overflow),
		.last(last)
	);

	// Shadow of the block state used for prediction.
	cfg_t              cfg_shadow;
	logic [15:0]       hist_shadow [NUM_BINS];
	logic [63:0]       slice_origin;
	longint unsigned   prefix_hits [NUM_BINS];
	trig_result_t      pending_triggers [$];

	int  error_count;
	int  items_sent;
	int  scans_sent;
	int  results_seen;
	int  nhits_seen;
	int  chan_seen;
	int  overflow_seen;
	int  stall_cycles;
	bit  gaps_off;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic trig_result_t make_result(input logic [1:0] k, input logic [3:0] t,
			input logic [63:0] tm, input logic o, input logic l);
		trig_result_t r;
		r.kind  = k;
		r.ttype = t;
		r.ttime = tm;
		r.ovf   = o;
		r.last  = l;
		return r;
	endfunction

	// Appends one expected result behind those already waiting.
	function automatic void expect_result(input trig_result_t r);
		pending_triggers.insert(pending_triggers.size(), r);
	endfunction

	function automatic void reset_predictor();
		cfg_shadow             = '0;
		cfg_shadow.threshold   = THRESHOLD_RST;
		cfg_shadow.window_bins = WINDOW_BINS_RST;
		cfg_shadow.skip_bins   = SKIP_BINS_RST;
		for (int b = 0; b < NUM_BINS; b++)
			hist_shadow[b] = '0;
		slice_origin = '0;
	endfunction

	// Window scan over the shadow histogram: one nhits trigger per firing
	// position up to the cap, then the done marker.
	function automatic void predict_scan();
		longint unsigned acc;
		longint unsigned w;
		longint unsigned i;
		longint unsigned lim;
		int              n;
		logic            ovf;
		acc = 0;
		for (int b = 0; b < NUM_BINS; b++) begin
			acc += 64'(hist_shadow[b]);
			prefix_hits[b] = acc;
		end
		w   = 64'(cfg_shadow.window_bins);
		n   = 0;
		ovf = 1'b0;
		if (w < 64'(NUM_BINS)) begin
			lim = 64'(NUM_BINS) - w;
			i   = w + 1;
			while (i < lim) begin
				if (prefix_hits[i] - prefix_hits[i - w] >= 64'(cfg_shadow.threshold)) begin
					if (n >= MAX_TRIGGERS) begin
						ovf = 1'b1;
						break;
					end
					expect_result(make_result(KIND_NHITS, 4'd0,
						((i - w) << BIN_SHIFT) + slice_origin, 1'b0, 1'b0));
					n++;
					i += 64'(cfg_shadow.skip_bins);
				end
				i++;
			end
		end
		expect_result(make_result(KIND_DONE, 4'd0, 64'd0, ovf, 1'b1));
	endfunction

	function automatic void predict_item(input logic [1:0] req, input logic [15:0] chan,
			input logic [63:0] htime, input logic [63:0] stime);
		logic [63:0] bin;
		case (req)
			REQ_OPEN: begin
				for (int b = 0; b < NUM_BINS; b++)
					hist_shadow[b] = '0;
				slice_origin = stime;
			end
			REQ_HIT: begin
				if (cfg_shadow.chan_enable[0] && chan == cfg_shadow.trig_chan_a) begin
					expect_result(make_result(KIND_CHAN, cfg_shadow.trig_type_a,
						htime, 1'b0, 1'b0));
				end else if (cfg_shadow.chan_enable[1] && chan == cfg_shadow.trig_chan_b) begin
					expect_result(make_result(KIND_CHAN, cfg_shadow.trig_type_b,
						htime, 1'b0, 1'b0));
				end else begin
					// Hits before the slice start wrap to a huge bin and drop out here.
					bin = (htime - slice_origin) >> BIN_SHIFT;
					if (bin < 64'(NUM_BINS) && hist_shadow[bin] != 16'hFFFF)
						hist_shadow[bin] = hist_shadow[bin] + 16'd1;
				end
			end
			REQ_CLOSE: predict_scan();
			default: ;
		endcase
	endfunction

	function automatic int pick_gap();
		if (gaps_off)
			return 0;
		return ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 15));
	endfunction

	function automatic logic [63:0] time_in_bin(input int unsigned bin);
		return slice_origin + (64'(bin) << BIN_SHIFT) + 64'($urandom_range(0, 511));
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [15:0] rand_chan();
		return 16'($urandom_range(0, 65535));
	endfunction

	task automatic send_item(input logic [1:0] req, input logic [15:0] chan,
			input logic [63:0] htime, input logic [63:0] stime);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		start      <= 1'b1;
		req_type   <= req;
		channel    <= chan;
		hit_time   <= htime;
		slice_time <= stime;
		do @(posedge clk); while (busy);
		predict_item(req, chan, htime, stime);
		if (req != REQ_UNUSED)
			items_sent++;
		if (req == REQ_CLOSE)
			scans_sent++;
	endtask

	task automatic send_hit(input logic [15:0] chan, input logic [63:0] htime);
		send_item(REQ_HIT, chan, htime, rand64());
	endtask

	task automatic send_open(input logic [63:0] stime);
		send_item(REQ_OPEN, rand_chan(), rand64(), stime);
	endtask

	task automatic send_close();
		send_item(REQ_CLOSE, rand_chan(), rand64(), rand64());
	endtask

	task automatic hold_until_drained();
		@(negedge clk);
		start <= 1'b0;
		while (pending_triggers.size() != 0)
			@(posedge clk);
	endtask

	// An open item leaves a clearing sweep running with nothing to show for it,
	// so the block gets a full sweep of quiet time before any register write.
	task automatic settle_block();
		hold_until_drained();
		repeat (IDLE_WAIT) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [15:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we    <= 1'b0;
		case (idx)
			REG_THRESHOLD:   cfg_shadow.threshold   = value;
			REG_WINDOW_BINS: cfg_shadow.window_bins = value[10:0];
			REG_SKIP_BINS:   cfg_shadow.skip_bins   = value[11:0];
			REG_CHAN_ENABLE: cfg_shadow.chan_enable = value[1:0];
			REG_TRIG_CHAN_A: cfg_shadow.trig_chan_a = value;
			REG_TRIG_TYPE_A: cfg_shadow.trig_type_a = value[3:0];
			REG_TRIG_CHAN_B: cfg_shadow.trig_chan_b = value;
			REG_TRIG_TYPE_B: cfg_shadow.trig_type_b = value[3:0];
			default: ;
		endcase
	endtask

	task automatic apply_config(input logic [15:0] thr, input logic [10:0] win,
			input logic [11:0] skip, input logic [1:0] en, input logic [15:0] cha,
			input logic [3:0] tya, input logic [15:0] chb, input logic [3:0] tyb);
		write_reg(REG_THRESHOLD, thr);
		write_reg(REG_WINDOW_BINS, 16'(win));
		write_reg(REG_SKIP_BINS, 16'(skip));
		write_reg(REG_CHAN_ENABLE, 16'(en));
		write_reg(REG_TRIG_CHAN_A, cha);
		write_reg(REG_TRIG_TYPE_A, 16'(tya));
		write_reg(REG_TRIG_CHAN_B, chb);
		write_reg(REG_TRIG_TYPE_B, 16'(tyb));
	endtask

	task automatic test_reset_defaults();
		// Empty histogram straight out of reset, then one cluster at the reset threshold.
		send_close();
		send_open(64'd0);
		for (int k = 0; k < 20; k++)
			send_hit(rand_chan(), time_in_bin(300));
		send_hit(16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF);
		send_close();
	endtask

	task automatic test_channel_triggers();
		settle_block();
		apply_config(16'd20, 11'd200, 12'd2000, 2'b11, 16'hFFFF, 4'hF, 16'h0000, 4'h5);
		send_hit(16'hFFFF, rand64());
		send_hit(16'h0000, rand64());
		send_hit(16'h1234, rand64());
		settle_block();
		// Both entries on the same channel: entry zero takes precedence.
		write_reg(REG_TRIG_CHAN_B, 16'hFFFF);
		write_reg(REG_TRIG_TYPE_B, 16'hA);
		send_hit(16'hFFFF, rand64());
		settle_block();
		write_reg(REG_CHAN_ENABLE, 16'd2);
		send_hit(16'hFFFF, rand64());
		settle_block();
		write_reg(REG_CHAN_ENABLE, 16'd0);
		send_hit(16'hFFFF, rand64());
	endtask

	task automatic test_scan_edges();
		logic [63:0] origin;
		settle_block();
		// Zero threshold fires at every position until the cap trips overflow.
		apply_config(16'd0, 11'd1, 12'd0, 2'b00, 16'd0, 4'd0, 16'd0, 4'd0);
		send_open(rand64());
		send_close();
		settle_block();
		write_reg(REG_WINDOW_BINS, 16'd0);
		write_reg(REG_THRESHOLD, 16'd1);
		send_close();
		settle_block();
		// Widest window leaves a single scan position; slice start sits near the wrap.
		write_reg(REG_WINDOW_BINS, 16'd2047);
		write_reg(REG_SKIP_BINS, 16'd4095);
		origin = 64'hFFFF_FFFF_FFFF_FE00;
		send_open(origin);
		send_hit(16'h5A5A, time_in_bin(2048));
		send_hit(16'h5A5A, origin - 64'd1);
		send_hit(16'hA5A5, time_in_bin(4095));
		send_hit(16'hA5A5, time_in_bin(4096));
		send_item(REQ_UNUSED, 16'hFFFF, rand64(), rand64());
		send_close();
		settle_block();
		apply_config(16'hFFFF, 11'd1024, 12'd4095, 2'b00, 16'd0, 4'd0, 16'd0, 4'd0);
		send_close();
	endtask

	// Back-to-back hits on one bin exercise the read-modify-write path.
	task automatic test_bin_burst();
		settle_block();
		apply_config(16'(BURST_HITS), 11'd1, 12'd0, 2'b00, 16'd0, 4'd0, 16'd0, 4'd0);
		send_open(rand64());
		gaps_off = 1'b1;
		for (int k = 0; k < BURST_HITS; k++)
			send_hit(rand_chan(), time_in_bin(700));
		gaps_off = 1'b0;
		send_hit(rand_chan(), time_in_bin(701));
		send_close();
	endtask

	task automatic test_random_slices();
		int          first_item;
		int          slices;
		int          hits;
		int unsigned cluster;
		logic [15:0] thr;
		logic [10:0] win;
		logic [11:0] skip;
		logic [15:0] cha;
		logic [15:0] chb;
		logic [63:0] origin;
		first_item = items_sent;
		while (items_sent - first_item < RANDOM_ITEMS) begin
			settle_block();
			case ($urandom_range(0, 9))
				0: thr = 16'd0;
				1: thr = 16'hFFFF;
				2: thr = 16'($urandom_range(1, 65535));
				default: thr = 16'($urandom_range(1, 6));
			endcase
			case ($urandom_range(0, 9))
				0: win = 11'd0;
				1: win = 11'd2047;
				2: win = 11'd1024;
				3: win = 11'($urandom_range(1, 2047));
				default: win = 11'($urandom_range(1, 40));
			endcase
			case ($urandom_range(0, 7))
				0: skip = 12'd4095;
				1: skip = 12'd0;
				2: skip = 12'($urandom_range(0, 4095));
				default: skip = 12'($urandom_range(0, 60));
			endcase
			cha = rand_chan();
			chb = ($urandom_range(0, 5) == 0) ? cha : rand_chan();
			apply_config(thr, win, skip, 2'($urandom_range(0, 3)), cha,
				4'($urandom_range(0, 15)), chb, 4'($urandom_range(0, 15)));
			gaps_off = ($urandom_range(0, 4) == 0);
			slices = int'($urandom_range(1, 3));
			for (int s = 0; s < slices; s++) begin
				origin = ($urandom_range(0, 3) == 0) ?
					64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 1 << 20)) : rand64();
				send_open(origin);
				hits    = int'($urandom_range(4, 20));
				cluster = $urandom_range(0, NUM_BINS - 1);
				for (int h = 0; h < hits; h++) begin
					case ($urandom_range(0, 19))
						0: send_hit(rand_chan(), rand64());
						1: send_item(REQ_UNUSED, rand_chan(), rand64(), rand64());
						2: send_hit(rand_chan(), ($urandom_range(0, 1) == 0) ?
							time_in_bin(NUM_BINS + $urandom_range(0, 3)) :
							slice_origin - 64'($urandom_range(1, 1 << 16)));
						3, 4: send_hit(cfg_shadow.trig_chan_a, rand64());
						5: send_hit(cfg_shadow.trig_chan_b, rand64());
						6: send_hit(rand_chan(),
							time_in_bin($urandom_range(0, NUM_BINS - 1)));
						default: send_hit(rand_chan(),
							time_in_bin(cluster + $urandom_range(0, 15)));
					endcase
				end
				send_close();
				// A second close repeats the scan over the untouched histogram.
				if ($urandom_range(0, 4) == 0)
					send_close();
				if ($urandom_range(0, 3) == 0)
					hold_until_drained();
			end
		end
		gaps_off = 1'b0;
	endtask

	task automatic note_mismatch(input string what, input trig_result_t want,
			input trig_result_t got);
		error_count++;
		if (error_count <= 10) begin
			$display("%0t %s: expected kind %0d type %0d time %h ovf %0b last %0b,",
				$time, what, want.kind, want.ttype, want.ttime, want.ovf, want.last);
			$display("    got kind %0d type %0d time %h ovf %0b last %0b",
				got.kind, got.ttype, got.ttime, got.ovf, got.last);
		end
	endtask

	always @(posedge clk) begin : result_check
		trig_result_t want;
		trig_result_t got;
		if (arst_n && strobe) begin
			got = make_result(kind, trig_type, trig_time, overflow, last);
			results_seen++;
			if (got.kind == KIND_NHITS)
				nhits_seen++;
			if (got.kind == KIND_CHAN)
				chan_seen++;
			if (got.ovf === 1'b1)
				overflow_seen++;
			if (pending_triggers.size() == 0) begin
				note_mismatch("result with nothing pending", '0, got);
			end else begin
				want = pending_triggers.pop_front();
				if (got.kind !== want.kind || got.ttype !== want.ttype ||
						got.ttime !== want.ttime || got.ovf !== want.ovf ||
						got.last !== want.last)
					note_mismatch("result mismatch", want, got);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || strobe) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("timeout after %0d cycles without progress", stall_cycles);
			$display("status: fail");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		arst_n       = 1'b0;
		start        = 1'b0;
		req_type     = REQ_OPEN;
		channel      = '0;
		hit_time     = '0;
		slice_time   = '0;
		cfg_we       = 1'b0;
		cfg_addr     = REG_THRESHOLD;
		cfg_wdata    = '0;
		gaps_off     = 1'b0;
		reset_predictor();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_defaults();
		test_channel_triggers();
		test_scan_edges();
		test_bin_burst();
		test_random_slices();

		hold_until_drained();
		repeat (IDLE_WAIT) @(posedge clk);
		if (pending_triggers.size() != 0)
			$display("%0d expected results never arrived", pending_triggers.size());
		$display("covered %0d items including %0d close scans; %0d results checked",
			items_sent, scans_sent, results_seen);
		$display("  (%0d nhits triggers, %0d channel triggers, %0d overflow markers),",
			nhits_seen, chan_seen, overflow_seen);
		$display("  %0d mismatches", error_count);
		if (error_count == 0 && pending_triggers.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

[filelist.f]
rtl/nwt_pkg.sv
rtl/nwt_front.sv
rtl/nwt_queue.sv
rtl/nwt_back.sv
rtl/nhits_window_trigger_core.sv
bench/tb_top.sv
